>>> rtl/core/ctpf_pkg.sv
// ctpf_pkg: shared constants and types for the circle pair tangency finder.
// No dependencies; imported by every module under rtl/core.
package ctpf_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_COORD_BITS = 16;
	localparam int RAD_W          = 16;
	localparam int IDX_OUT_W      = 6;

	localparam logic KIND_EXTERNAL = 1'b0;
	localparam logic KIND_INTERNAL = 1'b1;

	typedef struct packed {
		logic valid;
		logic last;
	} cmp_tag_t;

	typedef struct packed {
		logic hit;
		logic kind;
		logic last;
	} cmp_res_t;

endpackage

>>> rtl/core/ctpf_cell.sv
// ctpf_cell: one storage cell of the circle ring; holds {x, y, r}.
// Depends on ctpf_pkg.
module ctpf_cell
	import ctpf_pkg::*;
#(
	parameter int CIRC_W = 2 * DEF_COORD_BITS + RAD_W
) (
	input  logic              clk,
	input  logic              shift,
	input  logic [CIRC_W-1:0] d,
	output logic [CIRC_W-1:0] q
);

	logic [CIRC_W-1:0] circ_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			circ_q <= d;
		end
	end

	assign q = circ_q;

endmodule

>>> rtl/core/ctpf_cmp.sv
// ctpf_cmp: three-stage tangency test of the new circle against one stored circle.
// Squared distance against squared radius sum and difference. Depends on ctpf_pkg.
module ctpf_cmp
	import ctpf_pkg::*;
#(
	parameter int CW = DEF_COORD_BITS,
	parameter int IW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic signed [CW-1:0] cur_x,
	input  logic signed [CW-1:0] cur_y,
	input  logic [RAD_W-1:0]     cur_r,
	input  logic signed [CW-1:0] st_x,
	input  logic signed [CW-1:0] st_y,
	input  logic [RAD_W-1:0]     st_r,
	input  cmp_tag_t             tag,
	input  logic [IW-1:0]        idx,
	output cmp_res_t             res,
	output logic [IW-1:0]        res_idx
);

	localparam int SQ_W   = 2 * CW + 2;
	localparam int RSQ_W  = 2 * RAD_W + 2;
	localparam int CMP_W  = (SQ_W + 1 > RSQ_W) ? SQ_W + 1 : RSQ_W;

	logic signed [CW:0] dx, dy;
	logic [CW:0]        adx, ady;
	logic [RAD_W:0]     rsum, rdiff;

	logic [CW:0]        adx_s1, ady_s1;
	logic [RAD_W:0]     rsum_s1, rdiff_s1;
	logic               req_s1;
	cmp_tag_t           tag_s1;
	logic [IW-1:0]      idx_s1;

	logic [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic [RSQ_W-1:0]   sqs_s2, sqd_s2;
	logic               coin_s2;
	cmp_tag_t           tag_s2;
	logic [IW-1:0]      idx_s2;

	logic [CMP_W-1:0]   d2;
	logic               ext_eq, int_eq;

	cmp_res_t           res_s3;
	logic [IW-1:0]      idx_s3;

	always_comb begin
		dx    = {cur_x[CW-1], cur_x} - {st_x[CW-1], st_x};
		dy    = {cur_y[CW-1], cur_y} - {st_y[CW-1], st_y};
		adx   = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
		ady   = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
		rsum  = {1'b0, cur_r} + {1'b0, st_r};
		rdiff = (cur_r > st_r) ? {1'b0, cur_r} - {1'b0, st_r} : {1'b0, st_r} - {1'b0, cur_r};
	end

	always_ff @(posedge clk) begin
		adx_s1   <= adx;
		ady_s1   <= ady;
		rsum_s1  <= rsum;
		rdiff_s1 <= rdiff;
		req_s1   <= (cur_r == st_r);
		idx_s1   <= idx;
		sqx_s2   <= adx_s1 * adx_s1;
		sqy_s2   <= ady_s1 * ady_s1;
		sqs_s2   <= rsum_s1 * rsum_s1;
		sqd_s2   <= rdiff_s1 * rdiff_s1;
		coin_s2  <= (adx_s1 == '0) && (ady_s1 == '0) && req_s1;
		idx_s2   <= idx_s1;
		idx_s3   <= idx_s2;
	end

	always_comb begin
		d2     = CMP_W'(sqx_s2) + CMP_W'(sqy_s2);
		ext_eq = (d2 == CMP_W'(sqs_s2));
		int_eq = (d2 == CMP_W'(sqd_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			res_s3 <= '0;
		end else begin
			tag_s1      <= tag;
			tag_s2      <= tag_s1;
			res_s3.hit  <= tag_s2.valid && !coin_s2 && (ext_eq || int_eq);
			res_s3.kind <= ext_eq ? KIND_EXTERNAL : KIND_INTERNAL;
			res_s3.last <= tag_s2.last;
		end
	end

	assign res     = res_s3;
	assign res_idx = idx_s3;

endmodule

>>> rtl/core/circle_pair_tangency_finder.sv
// circle_pair_tangency_finder: ring of circle cells rotating past one tangency comparator.
// Each accepted circle takes one full ring turn, the three compare stages and one
// output beat; busy is high through the ring turn and compare stages, one circle at a time.
// A circle ignored because the store is full starts no ring turn. Results are one-cycle beats.
// arst_n clears the circle count and all control; stored circles are not cleared.
// Depends on ctpf_pkg, ctpf_cell, ctpf_cmp.
module circle_pair_tangency_finder
	import ctpf_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [15:0]   center_x,
	input  logic signed [15:0]   center_y,
	input  logic [RAD_W-1:0]     radius,
	input  logic                 start_new,
	output logic                 result_strobe,
	output logic [IDX_OUT_W-1:0] earlier_index,
	output logic [IDX_OUT_W-1:0] new_index,
	output logic                 tangency_kind,
	output logic                 last_pair
);

	localparam int CW     = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int CIRC_W = 2 * CW + RAD_W;
	localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	logic [CIRC_W-1:0] ring [CAPACITY];
	logic [CIRC_W-1:0] tail_d;

	logic                 scan_q;
	logic [IW-1:0]        k_q;
	logic [CNT_W-1:0]     count_q;
	logic [IW-1:0]        new_idx_q;
	logic signed [CW-1:0] cur_x_q, cur_y_q;
	logic [RAD_W-1:0]     cur_r_q;

	logic                 accept, take, scan_end;
	cmp_tag_t             tag;
	cmp_res_t             res;
	logic [IW-1:0]        res_idx;
	logic                 end_s1_q, end_s2_q;

	logic                 pend_q;
	logic [IW-1:0]        pend_idx_q;
	logic                 pend_kind_q;

	logic                 emit, emit_last;
	logic                 strobe_q, last_q, kind_q;
	logic [IW-1:0]        eidx_q, nidx_q;

	assign accept   = start && !busy;
	assign take     = accept && (start_new || (count_q < CNT_W'(CAPACITY)));
	assign scan_end = scan_q && (k_q == IW'(CAPACITY - 1));
	assign busy     = scan_q || end_s1_q || end_s2_q || res.last;

	// ring: cell 0 is the comparator tap, data moves towards it
	assign tail_d = (CNT_W'(k_q) == count_q) ? {cur_x_q, cur_y_q, cur_r_q} : ring[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ctpf_cell #(.CIRC_W(CIRC_W)) u_cell (
			.clk   (clk),
			.shift (scan_q),
			.d     ((i == CAPACITY - 1) ? tail_d : ring[(i + 1) % CAPACITY]),
			.q     (ring[i])
		);
	end

	always_comb begin
		tag.valid = scan_q && (CNT_W'(k_q) < count_q);
		tag.last  = scan_end;
	end

	ctpf_cmp #(.CW(CW), .IW(IW)) u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cur_x   (cur_x_q),
		.cur_y   (cur_y_q),
		.cur_r   (cur_r_q),
		.st_x    (ring[0][CIRC_W-1 -: CW]),
		.st_y    (ring[0][RAD_W+CW-1 -: CW]),
		.st_r    (ring[0][RAD_W-1:0]),
		.tag     (tag),
		.idx     (k_q),
		.res     (res),
		.res_idx (res_idx)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			cur_x_q   <= center_x[CW-1:0];
			cur_y_q   <= center_y[CW-1:0];
			cur_r_q   <= radius;
			new_idx_q <= start_new ? '0 : IW'(count_q);
		end
		if (res.hit) begin
			pend_idx_q  <= res_idx;
			pend_kind_q <= res.kind;
		end
		if (emit) begin
			eidx_q <= pend_idx_q;
			nidx_q <= new_idx_q;
			kind_q <= pend_kind_q;
			last_q <= emit_last;
		end
	end

	// a found pair is held back one hit so the final one can be marked
	assign emit      = pend_q && (res.hit || res.last);
	assign emit_last = res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= 1'b0;
			k_q      <= '0;
			count_q  <= '0;
			end_s1_q <= 1'b0;
			end_s2_q <= 1'b0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			end_s1_q <= scan_end;
			end_s2_q <= end_s1_q;
			strobe_q <= emit;
			if (res.hit) begin
				pend_q <= 1'b1;
			end else if (res.last) begin
				pend_q <= 1'b0;
			end
			if (accept && start_new) begin
				count_q <= '0;
			end else if (scan_end) begin
				count_q <= count_q + 1'b1;
			end
			if (take) begin
				scan_q <= 1'b1;
				k_q    <= '0;
			end else if (scan_q) begin
				k_q <= k_q + 1'b1;
				if (scan_end) begin
					scan_q <= 1'b0;
				end
			end
		end
	end

	assign result_strobe = strobe_q;
	assign earlier_index = IDX_OUT_W'(eidx_q);
	assign new_index     = IDX_OUT_W'(nidx_q);
	assign tangency_kind = kind_q;
	assign last_pair     = last_q;

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_pair |-> !busy)
		else $error("final beat while still busy");

	a_take_scans: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> scan_q && (k_q == '0))
		else $error("accepted circle did not start a ring turn");

	a_scan_room: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q |-> (count_q < CNT_W'(CAPACITY)))
		else $error("ring turn with a full store");

	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		res.last |-> !res.hit)
		else $error("hit on the closing slot of a ring turn");

endmodule
